// File: rtl/winograd_filter_transform_top_assert.svh
// ---------------------------------------------------------------------------
// Winograd filter transform: assertion macros
// Property wrappers clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef WINOGRAD_FILTER_TRANSFORM_TOP_ASSERT_SVH
`define WINOGRAD_FILTER_TRANSFORM_TOP_ASSERT_SVH

// Same-cycle implication.
`define WFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wft_pkg.sv
// ---------------------------------------------------------------------------
// wft_pkg
// Shared widths, coefficients, types and helpers of the filter transform.
// ---------------------------------------------------------------------------
`default_nettype none

package wft_pkg;

  localparam int MAX_OUTPUTS  = 512;
  localparam int MAX_CHANNELS = 512;

  localparam int CFG_W   = 10;
  localparam int IDX_W   = 9;
  localparam int WT_W    = 16;
  localparam int VAL_W   = 20;
  localparam int POS_W   = 6;
  localparam int ADDR_W  = 24;
  localparam int NC_W    = 2 * CFG_W;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int REG_LSB = 2;

  localparam int TILE_N     = 6;
  localparam int KERN_N     = 3;
  localparam int TILE_ELEMS = TILE_N * TILE_N;
  localparam int ROW_W      = $clog2(TILE_N);
  localparam int COL_W      = $clog2(KERN_N);

  // Q2.16 coefficient, intermediate G*f (Q.28), products and sum (Q.44)
  localparam int G_W       = 18;
  localparam int T_W       = 34;
  localparam int P_W       = T_W + G_W;
  localparam int ACC_W     = P_W + 2;
  localparam int FRAC_DROP = 32;
  localparam int RND_W     = ACC_W - FRAC_DROP;

  localparam logic signed [ACC_W-1:0] RND_BIAS =
    {{(ACC_W-FRAC_DROP){1'b0}}, 1'b1, {(FRAC_DROP-1){1'b0}}};

  localparam logic signed [G_W-1:0] G_ONE = 18'sd65536;  // 1
  localparam logic signed [G_W-1:0] G_A   = 18'sd43691;  // 2/3
  localparam logic signed [G_W-1:0] G_B   = 18'sd30894;  // sqrt2/3
  localparam logic signed [G_W-1:0] G_C   = 18'sd21845;  // 1/3
  localparam logic signed [G_W-1:0] G_D   = 18'sd10923;  // 1/6
  localparam logic signed [G_W-1:0] G_E   = 18'sd15447;  // sqrt2/6

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [PADDR_W-REG_LSB-1:0] {
    REG_NUM_OUTPUTS  = 1'b0,
    REG_NUM_CHANNELS = 1'b1
  } reg_idx_t;

  typedef logic [T_W-1:0] tval_t;

  // One kernel after the column pass: G*f plus its base layout address.
  typedef struct packed {
    tval_t [TILE_N-1:0][KERN_N-1:0] t;
    logic  [ADDR_W-1:0]             base;
  } kern_t;

  // Entry (row, col) of the 6x3 transform matrix G.
  function automatic logic signed [G_W-1:0] gcoef(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic signed [G_W-1:0] g;
    g = '0;
    case (row)
      3'd0: g = (col == 2'd0) ? G_ONE : '0;
      3'd1: begin
        case (col)
          2'd0:    g = -G_A;
          2'd1:    g = -G_B;
          2'd2:    g = -G_C;
          default: g = '0;
        endcase
      end
      3'd2: begin
        case (col)
          2'd0:    g = -G_A;
          2'd1:    g = G_B;
          2'd2:    g = -G_C;
          default: g = '0;
        endcase
      end
      3'd3: begin
        case (col)
          2'd0:    g = G_D;
          2'd1:    g = G_E;
          2'd2:    g = G_C;
          default: g = '0;
        endcase
      end
      3'd4: begin
        case (col)
          2'd0:    g = G_D;
          2'd1:    g = -G_E;
          2'd2:    g = G_C;
          default: g = '0;
        endcase
      end
      3'd5: g = (col == 2'd2) ? G_ONE : '0;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wft_in_if.sv
// ---------------------------------------------------------------------------
// wft_in_if
// Kernel channel: valid/ready plus indices and nine Q4.12 weights.
// ---------------------------------------------------------------------------
`default_nettype none

interface wft_in_if;
  logic                             valid;
  logic                             ready;
  logic [wft_pkg::IDX_W-1:0]        out_index;
  logic [wft_pkg::IDX_W-1:0]        chan_index;
  logic signed [wft_pkg::WT_W-1:0]  w_r0c0;
  logic signed [wft_pkg::WT_W-1:0]  w_r0c1;
  logic signed [wft_pkg::WT_W-1:0]  w_r0c2;
  logic signed [wft_pkg::WT_W-1:0]  w_r1c0;
  logic signed [wft_pkg::WT_W-1:0]  w_r1c1;
  logic signed [wft_pkg::WT_W-1:0]  w_r1c2;
  logic signed [wft_pkg::WT_W-1:0]  w_r2c0;
  logic signed [wft_pkg::WT_W-1:0]  w_r2c1;
  logic signed [wft_pkg::WT_W-1:0]  w_r2c2;

  modport source (
    output valid, out_index, chan_index,
    output w_r0c0, w_r0c1, w_r0c2, w_r1c0, w_r1c1, w_r1c2, w_r2c0, w_r2c1, w_r2c2,
    input  ready
  );

  modport sink (
    input  valid, out_index, chan_index,
    input  w_r0c0, w_r0c1, w_r0c2, w_r1c0, w_r1c1, w_r1c2, w_r2c0, w_r2c1, w_r2c2,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/wft_out_if.sv
// ---------------------------------------------------------------------------
// wft_out_if
// Result channel: valid/ready plus one transformed tile element.
// ---------------------------------------------------------------------------
`default_nettype none

interface wft_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wft_pkg::VAL_W-1:0] tile_value;
  logic [wft_pkg::POS_W-1:0]        tile_pos;
  logic [wft_pkg::ADDR_W-1:0]       dest_addr;
  logic                             last;

  modport source (
    output valid, tile_value, tile_pos, dest_addr, last,
    input  ready
  );

  modport sink (
    input  valid, tile_value, tile_pos, dest_addr, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/wft_front.sv
// ---------------------------------------------------------------------------
// wft_front
// Accept a kernel and form G*f one weight column per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module wft_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  wft_in_if.sink                             in_ch,
  input  wire logic [wft_pkg::CFG_W-1:0]     num_outputs,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output wft_pkg::kern_t                     push_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COL,
    ST_PUSH
  } state_t;

  state_t                                state;
  logic [wft_pkg::COL_W-1:0]             col;
  logic signed [wft_pkg::WT_W-1:0]       wt [wft_pkg::KERN_N][wft_pkg::KERN_N];
  logic [wft_pkg::IDX_W-1:0]             oidx;
  logic [wft_pkg::IDX_W-1:0]             cidx;
  wft_pkg::kern_t                        kern;

  logic                                  take;
  logic [wft_pkg::IDX_W+wft_pkg::CFG_W-1:0] cn;
  logic [wft_pkg::ADDR_W-1:0]            base_calc;
  logic signed [wft_pkg::T_W-1:0]        w0, w1, w2;
  logic signed [wft_pkg::T_W-1:0]        sa, sb, sc, sd;
  logic signed [wft_pkg::T_W-1:0]        tnew [wft_pkg::TILE_N];

  assign in_ch.ready = (state == ST_IDLE) || ((state == ST_PUSH) && push_ready);
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = (state == ST_PUSH);
  assign push_data   = kern;

  // Base address of this kernel: chan * outputs + out.
  assign cn        = cidx * num_outputs;
  assign base_calc = wft_pkg::ADDR_W'(cn) + wft_pkg::ADDR_W'(oidx);

  // Column 0 of the weight shift line is the column in work.
  always_comb begin
    w0 = wft_pkg::T_W'(wt[0][0]);
    w1 = wft_pkg::T_W'(wt[1][0]);
    w2 = wft_pkg::T_W'(wt[2][0]);
    sa = w0 * wft_pkg::G_A + w2 * wft_pkg::G_C;
    sb = w1 * wft_pkg::G_B;
    sc = w0 * wft_pkg::G_D + w2 * wft_pkg::G_C;
    sd = w1 * wft_pkg::G_E;
    tnew[0] = w0 * wft_pkg::G_ONE;
    tnew[1] = -sa - sb;
    tnew[2] = sb - sa;
    tnew[3] = sc + sd;
    tnew[4] = sc - sd;
    tnew[5] = w2 * wft_pkg::G_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_COL;
            col   <= '0;
          end
        end
        ST_COL: begin
          col <= col + 1'b1;
          if (col == wft_pkg::COL_W'(wft_pkg::KERN_N - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= take ? ST_COL : ST_IDLE;
            col   <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // Payload: load on transfer, shift one column per compute cycle.
    if (take) begin
      oidx     <= in_ch.out_index;
      cidx     <= in_ch.chan_index;
      wt[0][0] <= in_ch.w_r0c0;
      wt[0][1] <= in_ch.w_r0c1;
      wt[0][2] <= in_ch.w_r0c2;
      wt[1][0] <= in_ch.w_r1c0;
      wt[1][1] <= in_ch.w_r1c1;
      wt[1][2] <= in_ch.w_r1c2;
      wt[2][0] <= in_ch.w_r2c0;
      wt[2][1] <= in_ch.w_r2c1;
      wt[2][2] <= in_ch.w_r2c2;
    end else if (state == ST_COL) begin
      for (int r = 0; r < wft_pkg::KERN_N; r++) begin
        for (int c = 0; c < wft_pkg::KERN_N - 1; c++) begin
          wt[r][c] <= wt[r][c+1];
        end
      end
    end

    if (state == ST_COL) begin
      for (int r = 0; r < wft_pkg::TILE_N; r++) begin
        for (int c = 0; c < wft_pkg::KERN_N - 1; c++) begin
          kern.t[r][c] <= kern.t[r][c+1];
        end
        kern.t[r][wft_pkg::KERN_N-1] <= tnew[r];
      end
      if (col == '0) begin
        kern.base <= base_calc;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/wft_queue.sv
// ---------------------------------------------------------------------------
// wft_queue
// Short FIFO of column-transformed kernels between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module wft_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wft_pkg::kern_t  push_data,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output wft_pkg::kern_t  pop_data
);

  wft_pkg::kern_t              entries [wft_pkg::Q_DEPTH];
  logic [wft_pkg::Q_AW-1:0]    wptr;
  logic [wft_pkg::Q_AW-1:0]    rptr;
  logic [wft_pkg::Q_AW:0]      cnt;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (cnt != (wft_pkg::Q_AW+1)'(wft_pkg::Q_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == wft_pkg::Q_AW'(wft_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == wft_pkg::Q_AW'(wft_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wft_back.sv
// ---------------------------------------------------------------------------
// wft_back
// Walk the 36 tile positions of the head kernel: multiply, sum, round, saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module wft_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wft_pkg::kern_t                  pop_data,
  input  wire logic [wft_pkg::NC_W-1:0]   nc,
  wft_out_if.source                       out_ch
);

  localparam logic [wft_pkg::POS_W-1:0] LAST_POS = wft_pkg::POS_W'(wft_pkg::TILE_ELEMS - 1);
  localparam logic [wft_pkg::ROW_W-1:0] LAST_RC  = wft_pkg::ROW_W'(wft_pkg::TILE_N - 1);

  logic [wft_pkg::ROW_W-1:0]         row;
  logic [wft_pkg::ROW_W-1:0]         colj;
  logic [wft_pkg::POS_W-1:0]         pos;
  logic [wft_pkg::ADDR_W-1:0]        addr_run;

  logic                              s1_valid;
  logic signed [wft_pkg::P_W-1:0]    s1_p [wft_pkg::KERN_N];
  logic [wft_pkg::POS_W-1:0]         s1_pos;
  logic [wft_pkg::ADDR_W-1:0]        s1_addr;
  logic                              s1_last;

  logic                              s2_valid;
  logic signed [wft_pkg::ACC_W-1:0]  s2_sum;
  logic [wft_pkg::POS_W-1:0]         s2_pos;
  logic [wft_pkg::ADDR_W-1:0]        s2_addr;
  logic                              s2_last;

  logic                              adv;
  logic                              issue;
  logic [wft_pkg::ADDR_W-1:0]        issue_addr;
  logic signed [wft_pkg::P_W-1:0]    prod [wft_pkg::KERN_N];
  logic signed [wft_pkg::ACC_W-1:0]  sum_next;

  function automatic logic signed [wft_pkg::VAL_W-1:0] sat_val(
    input logic signed [wft_pkg::ACC_W-1:0] s
  );
    logic signed [wft_pkg::RND_W-1:0]           x;
    logic [wft_pkg::RND_W-wft_pkg::VAL_W:0]     top;
    logic signed [wft_pkg::VAL_W-1:0]           r;
    x   = s[wft_pkg::ACC_W-1:wft_pkg::FRAC_DROP];
    top = x[wft_pkg::RND_W-1:wft_pkg::VAL_W-1];
    if ((top == '0) || (top == '1)) begin
      r = x[wft_pkg::VAL_W-1:0];
    end else if (x[wft_pkg::RND_W-1]) begin
      r = {1'b1, {(wft_pkg::VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(wft_pkg::VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Whole pipeline moves together; stall only when the result is held.
  assign adv        = !out_ch.valid || out_ch.ready;
  assign issue      = pop_valid && adv;
  assign pop_ready  = issue && (pos == LAST_POS);
  assign issue_addr = (pos == '0) ? pop_data.base : addr_run;

  always_comb begin
    for (int k = 0; k < wft_pkg::KERN_N; k++) begin
      prod[k] = $signed(pop_data.t[row][k]) * wft_pkg::gcoef(colj, wft_pkg::COL_W'(k));
    end
    sum_next = wft_pkg::ACC_W'(s1_p[0]) + wft_pkg::ACC_W'(s1_p[1])
             + wft_pkg::ACC_W'(s1_p[2]) + wft_pkg::RND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= '0;
      colj         <= '0;
      pos          <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= pop_valid;
      s2_valid     <= s1_valid;
      out_ch.valid <= s2_valid;
      if (issue) begin
        pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
        if (colj == LAST_RC) begin
          colj <= '0;
          row  <= (row == LAST_RC) ? '0 : row + 1'b1;
        end else begin
          colj <= colj + 1'b1;
        end
      end
    end

    if (issue) begin
      addr_run <= issue_addr + wft_pkg::ADDR_W'(nc);
    end

    if (adv) begin
      for (int k = 0; k < wft_pkg::KERN_N; k++) begin
        s1_p[k] <= prod[k];
      end
      s1_pos  <= pos;
      s1_addr <= issue_addr;
      s1_last <= (pos == LAST_POS);

      s2_sum  <= sum_next;
      s2_pos  <= s1_pos;
      s2_addr <= s1_addr;
      s2_last <= s1_last;

      out_ch.tile_value <= sat_val(s2_sum);
      out_ch.tile_pos   <= s2_pos;
      out_ch.dest_addr  <= s2_addr;
      out_ch.last       <= s2_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/winograd_filter_transform_top.sv
// ---------------------------------------------------------------------------
// Winograd F(4x4,3x3) filter transform
// Turns 3x3 Q4.12 kernels into 6x6 transformed tiles G*f*G^T with layout
// addresses, one tile element per result transfer.
// ---------------------------------------------------------------------------
// Each kernel transferred on in_ch yields 36 results on out_ch in row-major
// tile order, the last one flagged. The back end emits one result per cycle
// while out_ch does not stall; that single result port bounds the throughput.
// The front end forms G*f column by column, then hands the kernel off, and
// runs ahead of the back end through a two-kernel queue, so a new kernel is
// taken while earlier ones are still being emitted and while a finished result
// waits on out_ch. The first result passes through the column pass, the queue
// and three back-end stages. The values are G*f kept exact, then (G*f)*G^T
// exact, rounded half up to Q8.12 and saturated to 20 bits.
// dest_addr = tile_pos*num_outputs*num_channels
// + chan_index*num_outputs + out_index, wrapped to 24 bits.
// Registers on the APB port: num_outputs at 0x0 and num_channels at 0x4, both
// 10 bits, reset 1, writes above 512 clamp to 512. paddr bits [1:0] are not
// decoded. Write them only while no kernel is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module winograd_filter_transform_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wft_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [wft_pkg::PDATA_W-1:0]   pwdata,
  output logic [wft_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  wft_in_if.sink                             in_ch,
  wft_out_if.source                          out_ch
);

  logic [wft_pkg::CFG_W-1:0]  num_outputs;
  logic [wft_pkg::CFG_W-1:0]  num_channels;
  logic [wft_pkg::NC_W-1:0]   nc;
  logic                       cfg_wr;
  wft_pkg::reg_idx_t          reg_sel;
  logic [wft_pkg::CFG_W-1:0]  wr_val;

  logic                       push_valid;
  logic                       push_ready;
  wft_pkg::kern_t             push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  wft_pkg::kern_t             pop_data;

  // APB: pready tied high, register picked by the word address.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = wft_pkg::reg_idx_t'(paddr[wft_pkg::PADDR_W-1:wft_pkg::REG_LSB]);
  assign wr_val  = pwdata[wft_pkg::CFG_W-1:0];

  always_comb begin
    case (reg_sel)
      wft_pkg::REG_NUM_OUTPUTS:  prdata = wft_pkg::PDATA_W'(num_outputs);
      wft_pkg::REG_NUM_CHANNELS: prdata = wft_pkg::PDATA_W'(num_channels);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_outputs  <= wft_pkg::CFG_W'(1);
      num_channels <= wft_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        wft_pkg::REG_NUM_OUTPUTS: begin
          // clamp to the largest supported filter count
          num_outputs <= (wr_val > wft_pkg::CFG_W'(wft_pkg::MAX_OUTPUTS)) ?
                         wft_pkg::CFG_W'(wft_pkg::MAX_OUTPUTS) : wr_val;
        end
        wft_pkg::REG_NUM_CHANNELS: begin
          num_channels <= (wr_val > wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS)) ?
                          wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS) : wr_val;
        end
        default: begin
          num_outputs <= num_outputs;
        end
      endcase
    end
    // Tile stride, registered; the user must let registers change only while idle (the block does not enforce it).
    nc <= num_outputs * num_channels;
  end

  // Front: take the kernel, form G*f and its base address.
  wft_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .num_outputs (num_outputs),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Queue: decouple front and back so each can stall on its own.
  wft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: one tile element per cycle while out_ch does not stall, registered result on out_ch.
  wft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .nc        (nc),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/wft_checker.sv
// ---------------------------------------------------------------------------
// wft_checker
// Port-level assertions for the filter transform, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "winograd_filter_transform_top_assert.svh"

module wft_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic                          pready,
  input wire logic [wft_pkg::PADDR_W-1:0]   paddr,
  input wire logic [wft_pkg::PDATA_W-1:0]   pwdata,
  input wire logic [wft_pkg::PDATA_W-1:0]   prdata,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [wft_pkg::VAL_W-1:0]     tile_value,
  input wire logic [wft_pkg::POS_W-1:0]     tile_pos,
  input wire logic [wft_pkg::ADDR_W-1:0]    dest_addr,
  input wire logic                          last
);

  localparam logic [wft_pkg::POS_W-1:0] LAST_POS = wft_pkg::POS_W'(wft_pkg::TILE_ELEMS - 1);
  localparam logic [wft_pkg::CFG_W-1:0] MAX_OUT  = wft_pkg::CFG_W'(wft_pkg::MAX_OUTPUTS);

  logic out_xfer;
  logic wr_out_reg;
  logic rd_out_reg;

  assign out_xfer   = out_valid && out_ready;
  assign wr_out_reg = psel && penable && pwrite && pready &&
                      (paddr[wft_pkg::PADDR_W-1:wft_pkg::REG_LSB] == wft_pkg::REG_NUM_OUTPUTS);
  assign rd_out_reg = (paddr[wft_pkg::PADDR_W-1:wft_pkg::REG_LSB] == wft_pkg::REG_NUM_OUTPUTS);

  // Hold a stalled result.
  `WFT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tile_value) && $stable(tile_pos) && $stable(dest_addr) && $stable(last), "result changed while stalled")

  // Flag the last element exactly at the final tile position.
  `WFT_ASSERT_IMP(a_last_pos, out_valid, last == (tile_pos == LAST_POS), "last flag and tile position disagree")

  // Advance the tile position by one within a kernel.
  `WFT_ASSERT_NXT(a_pos_step, out_xfer && !last, !out_xfer || (tile_pos == $past(tile_pos) + 1'b1), "tile position skipped or repeated")

  // Restart at position zero after a last element.
  `WFT_ASSERT_NXT(a_pos_wrap, out_xfer && last, !out_xfer || (tile_pos == '0), "new kernel does not start at position zero")

  // Read back an in-range write to the output count register.
  `WFT_ASSERT_NXT(a_cfg_rdback, wr_out_reg && (pwdata[wft_pkg::CFG_W-1:0] <= MAX_OUT), !rd_out_reg || (prdata[wft_pkg::CFG_W-1:0] == $past(pwdata[wft_pkg::CFG_W-1:0])), "num_outputs readback mismatch")

endmodule

bind winograd_filter_transform_top wft_checker u_wft_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .pready     (pready),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .tile_value (out_ch.tile_value),
  .tile_pos   (out_ch.tile_pos),
  .dest_addr  (out_ch.dest_addr),
  .last       (out_ch.last)
);

`default_nettype wire
